// ===== design/qnl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_pkg
// Shared widths, constants and the queue word for the quaternion blend.
// ----------------------------------------------------------------------------
package qnl_pkg;

    localparam int COMP_W      = 16;
    localparam int WEIGHT_W    = 16;
    localparam int UNIT_Q14    = 16384;
    localparam int ONE_Q15     = 32768;
    localparam int FRAC_B      = 14;
    localparam int QW          = 15;
    localparam int IN_SHIFT    = 8;
    localparam int VEC_W       = COMP_W + IN_SHIFT;
    localparam int BLEND_W     = 31;
    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        comp_t [3:0]         a;
        comp_t [3:0]         b;
        logic [WEIGHT_W-1:0] w;
        logic [WEIGHT_W-1:0] om;
    } qnl_item_t;

    // magnitude, square, sum, root stages, numerator, divide stages, output stage
    function automatic int unit_lat(input int vw);
        return vw + QW + 6;
    endfunction

endpackage

// ===== design/quaternion_nlerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_nlerp
// Normalized linear blend of two Q1.14 quaternions along the shorter arc.
//
//   side    | handshake       | words
//   --------+-----------------+-------------------------------------------
//   input   | push / full     | start_x..start_w, end_x..end_w, weight
//   result  | pop / empty     | out_x, out_y, out_z, out_w
//
// One word in and one word out per cycle, sustained while each result is popped.
// Latency is set by the root and quotient stages of the three scaling units
// (one bit per stage).
// Reset clears the queue pointers and count and all valid flags; no state else.
// A held result stalls the whole arithmetic pipeline; the input stage and
// queue keep taking words until the queue fills and the input stage holds one.
// ----------------------------------------------------------------------------
module quaternion_nlerp import qnl_pkg::*;
#(
    parameter int QUEUE_DEPTH = qnl_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  comp_t               start_x,
    input  comp_t               start_y,
    input  comp_t               start_z,
    input  comp_t               start_w,
    input  comp_t               end_x,
    input  comp_t               end_y,
    input  comp_t               end_z,
    input  comp_t               end_w,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                pop,
    output logic                empty,
    output comp_t               out_x,
    output comp_t               out_y,
    output comp_t               out_z,
    output comp_t               out_w
);

    logic      q_full;
    logic      q_push;
    qnl_item_t q_item;
    logic      q_pop;
    logic      q_empty;
    qnl_item_t q_head;

    qnl_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .start_x (start_x),
        .start_y (start_y),
        .start_z (start_z),
        .start_w (start_w),
        .end_x   (end_x),
        .end_y   (end_y),
        .end_z   (end_z),
        .end_w   (end_w),
        .weight  (weight),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_item)
    );

    qnl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    qnl_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .out_x   (out_x),
        .out_y   (out_y),
        .out_z   (out_z),
        .out_w   (out_w)
    );

endmodule

// ===== design/qnl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_front
// Input stage: takes a word, saturates the weight and forms its complement.
// ----------------------------------------------------------------------------
module qnl_front import qnl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  comp_t               start_x,
    input  comp_t               start_y,
    input  comp_t               start_z,
    input  comp_t               start_w,
    input  comp_t               end_x,
    input  comp_t               end_y,
    input  comp_t               end_z,
    input  comp_t               end_w,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic                q_full,
    output logic                q_push,
    output qnl_item_t           q_item
);

    logic                valid_reg;
    logic                valid_next;
    qnl_item_t           item_reg;
    logic                accept;
    logic [WEIGHT_W-1:0] w_sat;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_item = item_reg;

    assign w_sat = (weight > WEIGHT_W'(ONE_Q15)) ? WEIGHT_W'(ONE_Q15) : weight;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.a  <= {start_w, start_z, start_y, start_x};
            item_reg.b  <= {end_w, end_z, end_y, end_x};
            item_reg.w  <= w_sat;
            item_reg.om <= WEIGHT_W'(ONE_Q15) - w_sat;
        end
    end

endmodule

// ===== design/qnl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_queue
// Short queue between the input stage and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module qnl_queue import qnl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  qnl_item_t din,
    output logic      full,
    input  logic      pop,
    output qnl_item_t dout,
    output logic      empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    qnl_item_t       mem [DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   wr_next;
    logic [AW-1:0]   rd_reg;
    logic [AW-1:0]   rd_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= din;
        end
    end

endmodule

// ===== design/qnl_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_unit
// Pipelined unit scaling of a 4-vector to Q1.14: magnitudes, squares, sum, one
// root bit per stage, rounded numerator, one quotient bit per stage, clamp and sign.
// ----------------------------------------------------------------------------
module qnl_unit import qnl_pkg::*;
#(
    parameter int VW = VEC_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ce,
    input  logic                 in_v,
    input  logic signed [VW-1:0] v [4],
    output logic                 out_v,
    output comp_t                u [4]
);

    localparam int SQW = 2 * VW + 1;
    localparam int RW  = VW + 1;
    localparam int NW  = VW + QW;

    // magnitude stage
    logic              a_v_reg;
    logic [VW-1:0]     a_mag_reg [4];
    logic [3:0]        a_neg_reg;
    // square stage
    logic              b_v_reg;
    logic [2*VW-1:0]   b_sq_reg [4];
    logic [VW-1:0]     b_mag_reg [4];
    logic [3:0]        b_neg_reg;
    // sum stage
    logic              c_v_reg;
    logic [SQW-1:0]    c_s_reg;
    logic [VW-1:0]     c_mag_reg [4];
    logic [3:0]        c_neg_reg;
    // root stages
    logic [RW-1:0]     sq_v_reg;
    logic [SQW-1:0]    sq_rem_reg [RW];
    logic [RW-1:0]     sq_root_reg [RW];
    logic [VW-1:0]     sq_mag_reg [RW][4];
    logic [3:0]        sq_neg_reg [RW];
    logic [SQW-1:0]    sq_rem_in [RW];
    logic [RW-1:0]     sq_root_in [RW];
    logic [VW-1:0]     sq_mag_in [RW][4];
    logic [3:0]        sq_neg_in [RW];
    logic [SQW-1:0]    sq_trial [RW];
    // numerator stage
    logic              n_v_reg;
    logic [NW-1:0]     n_num_reg [4];
    logic [RW-1:0]     n_den_reg;
    logic              n_zero_reg;
    logic [3:0]        n_neg_reg;
    // divide stages
    logic [QW-1:0]     dv_v_reg;
    logic [NW-1:0]     dv_rem_reg [QW][4];
    logic [QW-1:0]     dv_q_reg [QW][4];
    logic [RW-1:0]     dv_den_reg [QW];
    logic              dv_zero_reg [QW];
    logic [3:0]        dv_neg_reg [QW];
    logic [NW-1:0]     dv_rem_in [QW][4];
    logic [QW-1:0]     dv_q_in [QW][4];
    logic [RW-1:0]     dv_den_in [QW];
    logic              dv_zero_in [QW];
    logic [3:0]        dv_neg_in [QW];
    logic [NW-1:0]     dv_trial [QW];
    // output stage
    logic              o_v_reg;
    comp_t             o_u_reg [4];
    logic [COMP_W-1:0] o_mag [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            c_v_reg  <= 1'b0;
            sq_v_reg <= '0;
            n_v_reg  <= 1'b0;
            dv_v_reg <= '0;
            o_v_reg  <= 1'b0;
        end
        else if (ce)
        begin
            a_v_reg  <= in_v;
            b_v_reg  <= a_v_reg;
            c_v_reg  <= b_v_reg;
            sq_v_reg <= {sq_v_reg[RW-2:0], c_v_reg};
            n_v_reg  <= sq_v_reg[RW-1];
            dv_v_reg <= {dv_v_reg[QW-2:0], n_v_reg};
            o_v_reg  <= dv_v_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
            begin
                a_mag_reg[i] <= v[i][VW-1] ? VW'(-v[i]) : VW'(v[i]);
                a_neg_reg[i] <= v[i][VW-1];
                b_sq_reg[i]  <= a_mag_reg[i] * a_mag_reg[i];
                b_mag_reg[i] <= a_mag_reg[i];
                c_mag_reg[i] <= b_mag_reg[i];
            end
            b_neg_reg <= a_neg_reg;
            c_neg_reg <= b_neg_reg;
            c_s_reg   <= SQW'(b_sq_reg[0]) + SQW'(b_sq_reg[1])
                       + SQW'(b_sq_reg[2]) + SQW'(b_sq_reg[3]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < RW; j++)
        begin
            if (j == 0)
            begin
                sq_rem_in[j]  = c_s_reg;
                sq_root_in[j] = '0;
                sq_neg_in[j]  = c_neg_reg;
                for (int i = 0; i < 4; i++)
                begin
                    sq_mag_in[j][i] = c_mag_reg[i];
                end
            end
            else
            begin
                sq_rem_in[j]  = sq_rem_reg[j-1];
                sq_root_in[j] = sq_root_reg[j-1];
                sq_neg_in[j]  = sq_neg_reg[j-1];
                for (int i = 0; i < 4; i++)
                begin
                    sq_mag_in[j][i] = sq_mag_reg[j-1][i];
                end
            end
            sq_trial[j] = (SQW'(sq_root_in[j]) << (RW - j))
                        | (SQW'(1) << (2 * (RW - 1 - j)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int j = 0; j < RW; j++)
            begin
                if (sq_rem_in[j] >= sq_trial[j])
                begin
                    sq_rem_reg[j]  <= sq_rem_in[j] - sq_trial[j];
                    sq_root_reg[j] <= sq_root_in[j] | (RW'(1) << (RW - 1 - j));
                end
                else
                begin
                    sq_rem_reg[j]  <= sq_rem_in[j];
                    sq_root_reg[j] <= sq_root_in[j];
                end
                sq_neg_reg[j] <= sq_neg_in[j];
                for (int i = 0; i < 4; i++)
                begin
                    sq_mag_reg[j][i] <= sq_mag_in[j][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
            begin
                n_num_reg[i] <= (NW'(sq_mag_reg[RW-1][i]) << FRAC_B)
                              + NW'(sq_root_reg[RW-1] >> 1);
            end
            n_den_reg  <= sq_root_reg[RW-1];
            n_zero_reg <= (sq_root_reg[RW-1] == '0);
            n_neg_reg  <= sq_neg_reg[RW-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                dv_den_in[k]  = n_den_reg;
                dv_zero_in[k] = n_zero_reg;
                dv_neg_in[k]  = n_neg_reg;
                for (int i = 0; i < 4; i++)
                begin
                    dv_rem_in[k][i] = n_num_reg[i];
                    dv_q_in[k][i]   = '0;
                end
            end
            else
            begin
                dv_den_in[k]  = dv_den_reg[k-1];
                dv_zero_in[k] = dv_zero_reg[k-1];
                dv_neg_in[k]  = dv_neg_reg[k-1];
                for (int i = 0; i < 4; i++)
                begin
                    dv_rem_in[k][i] = dv_rem_reg[k-1][i];
                    dv_q_in[k][i]   = dv_q_reg[k-1][i];
                end
            end
            dv_trial[k] = NW'(dv_den_in[k]) << (QW - 1 - k);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < QW; k++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (dv_rem_in[k][i] >= dv_trial[k])
                    begin
                        dv_rem_reg[k][i] <= dv_rem_in[k][i] - dv_trial[k];
                        dv_q_reg[k][i]   <= dv_q_in[k][i] | (QW'(1) << (QW - 1 - k));
                    end
                    else
                    begin
                        dv_rem_reg[k][i] <= dv_rem_in[k][i];
                        dv_q_reg[k][i]   <= dv_q_in[k][i];
                    end
                end
                dv_den_reg[k]  <= dv_den_in[k];
                dv_zero_reg[k] <= dv_zero_in[k];
                dv_neg_reg[k]  <= dv_neg_in[k];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            o_mag[i] = (dv_q_reg[QW-1][i] > QW'(UNIT_Q14)) ? COMP_W'(UNIT_Q14)
                                                           : COMP_W'(dv_q_reg[QW-1][i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (dv_zero_reg[QW-1])
                begin
                    o_u_reg[i] <= '0;
                end
                else if (dv_neg_reg[QW-1][i])
                begin
                    o_u_reg[i] <= comp_t'(-o_mag[i]);
                end
                else
                begin
                    o_u_reg[i] <= comp_t'(o_mag[i]);
                end
            end
        end
    end

    assign out_v = o_v_reg;
    assign u     = o_u_reg;

endmodule

// ===== design/qnl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qnl_back
// Arithmetic pipeline: scale both inputs, dot product and sign fix, blend,
// scale the blend, hold the result word.
// ----------------------------------------------------------------------------
module qnl_back import qnl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  qnl_item_t q_head,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output comp_t     out_x,
    output comp_t     out_y,
    output comp_t     out_z,
    output comp_t     out_w
);

    localparam int LAT_U = unit_lat(VEC_W);
    localparam int PW    = 2 * COMP_W;
    localparam int DW    = PW + 2;
    localparam int MW    = 2 * COMP_W + 1;

    logic                    ce;
    logic signed [VEC_W-1:0] va [4];
    logic signed [VEC_W-1:0] vb [4];
    logic                    ua_v;
    logic                    ub_v;
    comp_t                   ua [4];
    comp_t                   ub [4];
    logic [WEIGHT_W-1:0]     wd_w_reg [LAT_U];
    logic [WEIGHT_W-1:0]     wd_om_reg [LAT_U];

    logic                    d1_v_reg;
    logic signed [PW-1:0]    d1_prod_reg [4];
    comp_t                   d1_a_reg [4];
    comp_t                   d1_b_reg [4];
    logic [WEIGHT_W-1:0]     d1_w_reg;
    logic [WEIGHT_W-1:0]     d1_om_reg;

    logic                    d2_v_reg;
    logic                    d2_neg_reg;
    comp_t                   d2_a_reg [4];
    comp_t                   d2_b_reg [4];
    logic [WEIGHT_W-1:0]     d2_w_reg;
    logic [WEIGHT_W-1:0]     d2_om_reg;
    logic signed [DW-1:0]    dot;

    logic                    d3_v_reg;
    logic signed [BLEND_W-1:0] d3_pa_reg [4];
    logic signed [BLEND_W-1:0] d3_pb_reg [4];
    comp_t                   bn [4];
    logic signed [MW-1:0]    pa [4];
    logic signed [MW-1:0]    pb [4];

    logic                      d4_v_reg;
    logic signed [BLEND_W-1:0] d4_r_reg [4];

    logic                    ur_v;
    comp_t                   ur [4];

    logic                    out_v_reg;
    comp_t                   out_reg [4];

    assign ce    = !out_v_reg || pop;
    assign q_pop = ce && !q_empty;
    assign empty = !out_v_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            va[i] = $signed({q_head.a[i], {IN_SHIFT{1'b0}}});
            vb[i] = $signed({q_head.b[i], {IN_SHIFT{1'b0}}});
        end
    end

    qnl_unit #(.VW(VEC_W)) u_unit_a
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .in_v  (q_pop),
        .v     (va),
        .out_v (ua_v),
        .u     (ua)
    );

    qnl_unit #(.VW(VEC_W)) u_unit_b
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .in_v  (q_pop),
        .v     (vb),
        .out_v (ub_v),
        .u     (ub)
    );

    // weight rides alongside the scaling units
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            wd_w_reg[0]  <= q_head.w;
            wd_om_reg[0] <= q_head.om;
            for (int s = 1; s < LAT_U; s++)
            begin
                wd_w_reg[s]  <= wd_w_reg[s-1];
                wd_om_reg[s] <= wd_om_reg[s-1];
            end
        end
    end

    always_comb
    begin
        dot = '0;
        for (int i = 0; i < 4; i++)
        begin
            dot = dot + DW'(d1_prod_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            bn[i] = d2_neg_reg ? comp_t'(-d2_b_reg[i]) : d2_b_reg[i];
            pa[i] = $signed(d2_a_reg[i]) * $signed({1'b0, d2_om_reg});
            pb[i] = $signed(bn[i]) * $signed({1'b0, d2_w_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_v_reg  <= 1'b0;
            d2_v_reg  <= 1'b0;
            d3_v_reg  <= 1'b0;
            d4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            d1_v_reg  <= ua_v && ub_v;
            d2_v_reg  <= d1_v_reg;
            d3_v_reg  <= d2_v_reg;
            d4_v_reg  <= d3_v_reg;
            out_v_reg <= ur_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d1_prod_reg[i] <= ua[i] * ub[i];
                d1_a_reg[i]    <= ua[i];
                d1_b_reg[i]    <= ub[i];
                d2_a_reg[i]    <= d1_a_reg[i];
                d2_b_reg[i]    <= d1_b_reg[i];
                d3_pa_reg[i]   <= pa[i][BLEND_W-1:0];
                d3_pb_reg[i]   <= pb[i][BLEND_W-1:0];
                d4_r_reg[i]    <= d3_pa_reg[i] + d3_pb_reg[i];
                out_reg[i]     <= ur[i];
            end
            d1_w_reg   <= wd_w_reg[LAT_U-1];
            d1_om_reg  <= wd_om_reg[LAT_U-1];
            d2_w_reg   <= d1_w_reg;
            d2_om_reg  <= d1_om_reg;
            d2_neg_reg <= dot[DW-1];
        end
    end

    qnl_unit #(.VW(BLEND_W)) u_unit_r
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .in_v  (d4_v_reg),
        .v     (d4_r_reg),
        .out_v (ur_v),
        .u     (ur)
    );

    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];
    assign out_w = out_reg[3];

endmodule
